// ===== rtl/fsp_pkg.sv =====
// shared types, character codes and helpers for the format specifier parser
package fsp_pkg;

  localparam int unsigned NumW = 31;

  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_LONG    = 8'h6C;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_C       = 8'h63;
  localparam logic [7:0] CH_S       = 8'h73;
  localparam logic [7:0] CH_P       = 8'h70;
  localparam logic [7:0] CH_D       = 8'h64;
  localparam logic [7:0] CH_I       = 8'h69;
  localparam logic [7:0] CH_U       = 8'h75;
  localparam logic [7:0] CH_LX      = 8'h78;
  localparam logic [7:0] CH_UX      = 8'h58;
  localparam logic [7:0] CH_F       = 8'h66;

  typedef enum logic [2:0] {
    PH_FLAGS = 3'd0,
    PH_WIDTH = 3'd1,
    PH_PREC  = 3'd2,
    PH_LONG  = 3'd3,
    PH_DONE  = 3'd4
  } fsp_phase_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_WIDTH_OVF = 2'd1,
    ST_BAD_CONV  = 2'd2
  } fsp_status_t;

  typedef struct packed {
    logic long_mod;
    logic dot;
    logic zero_pad;
    logic space_sign;
    logic force_sign;
    logic left_align;
    logic alt_form;
  } fsp_flags_t;

  typedef struct packed {
    logic              prec_overflow;
    logic [NumW-1:0]   prec_value;
    logic [NumW-1:0]   field_width;
    logic              long_mod;
    logic              has_precision;
    logic              zero_pad;
    logic              space_sign;
    logic              force_sign;
    logic              left_align;
    logic              alt_form;
    logic [7:0]        conv_char;
    fsp_status_t       status;
  } fsp_result_t;

  function automatic logic known_conv(input logic [7:0] c);
    logic hit;
    hit = (c == CH_PERCENT) || (c == CH_C) || (c == CH_S) || (c == CH_P) ||
          (c == CH_D) || (c == CH_I) || (c == CH_U) || (c == CH_LX) ||
          (c == CH_UX) || (c == CH_F);
    return hit;
  endfunction

endpackage

// ===== rtl/fsp_dec_acc.sv =====
// decimal accumulate step: acc * 10 + digit with 31-bit overflow detect
module fsp_dec_acc (
  input  logic [fsp_pkg::NumW-1:0] acc,
  input  logic [3:0]               digit,
  output logic [fsp_pkg::NumW-1:0] sum,
  output logic                     ovf
);
  import fsp_pkg::*;

  logic [NumW+3:0] wide;

  // times ten as shift-and-add
  assign wide = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{NumW{1'b0}}, digit};
  assign sum  = wide[NumW-1:0];
  assign ovf  = |wide[NumW+3:NumW];

endmodule

// ===== rtl/fsp_out_reg.sv =====
// result register with stream handshake toward the consumer
module fsp_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  fsp_pkg::fsp_result_t load_data,
  input  logic                tready,
  output logic                tvalid,
  output fsp_pkg::fsp_result_t data,
  output logic                free
);
  import fsp_pkg::*;

  logic        valid_r, valid_nxt;
  fsp_result_t data_r;

  assign free = !valid_r || tready;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (tready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign tvalid = valid_r;
  assign data   = data_r;

endmodule

// ===== rtl/format_spec_parser.sv =====
// format specifier parser top level: phase tracking, field collection, result stream
// a terminating byte shows its result in the cycle after it is accepted
// throughput: one byte per cycle unless stalled; parse state updates in the accept
//   cycle, so the multiply-by-ten add plus phase decode is the only path per byte
// in_tready drops only while the result register is full and not being taken
// reset (rst_n low, synchronous): flags phase, all fields clear, no result pending
module format_spec_parser (
  input  logic        clk,
  input  logic        rst_n,
  // input transaction
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic [0:0]  in_tuser,   // [0] start_req
  // result transaction
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] status, [9:2] conv_char, [10] alt_form, [11] left_align,
  // [12] force_sign, [13] space_sign, [14] zero_pad, [15] has_precision,
  // [16] long_mod, [47:17] field_width, [78:48] prec_value, [79] prec_overflow
  output logic [79:0] out_tdata
);
  import fsp_pkg::*;

  // parse state
  fsp_phase_t      phase_r, phase_nxt;
  fsp_flags_t      flags_r, flags_nxt;
  logic [NumW-1:0] wacc_r, wacc_nxt;
  logic [NumW-1:0] pacc_r, pacc_nxt;
  logic            povf_r, povf_nxt;

  // state as seen by this byte (start_req clears it first)
  fsp_phase_t      cur_phase;
  fsp_flags_t      cur_flags;
  logic [NumW-1:0] cur_wacc;
  logic [NumW-1:0] cur_pacc;
  logic            cur_povf;

  logic [7:0]      ch;
  logic            start;
  logic            is_digit;
  logic            in_xfer;
  logic            out_free;

  logic [NumW-1:0] wsum, psum;
  logic            wovf, povf_step;

  logic            do_wdigit, do_after, do_finish;
  logic            emit;
  logic            prec_ok;
  fsp_result_t     res;
  fsp_result_t     out_res;

  assign ch       = in_tdata;
  assign start    = in_tuser[0];
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign in_xfer  = in_tvalid && in_tready;

  // a new transaction is taken whenever the result register can absorb one
  assign in_tready = out_free;

  assign cur_phase = start ? PH_FLAGS : phase_r;
  assign cur_flags = start ? '0 : flags_r;
  assign cur_wacc  = start ? '0 : wacc_r;
  assign cur_pacc  = start ? '0 : pacc_r;
  assign cur_povf  = start ? 1'b0 : povf_r;

  // width and precision each get their own times-ten adder
  fsp_dec_acc u_wacc (
    .acc   (cur_wacc),
    .digit (ch[3:0]),
    .sum   (wsum),
    .ovf   (wovf)
  );

  fsp_dec_acc u_pacc (
    .acc   (cur_pacc),
    .digit (ch[3:0]),
    .sum   (psum),
    .ovf   (povf_step)
  );

  always_comb begin
    phase_nxt = cur_phase;
    flags_nxt = cur_flags;
    wacc_nxt  = cur_wacc;
    pacc_nxt  = cur_pacc;
    povf_nxt  = cur_povf;
    do_wdigit = 1'b0;
    do_after  = 1'b0;
    do_finish = 1'b0;
    emit      = 1'b0;
    prec_ok   = cur_flags.dot && !cur_povf;

    res.status        = ST_OK;
    res.conv_char     = ch;
    res.alt_form      = cur_flags.alt_form;
    res.left_align    = cur_flags.left_align;
    res.force_sign    = cur_flags.force_sign;
    res.space_sign    = cur_flags.space_sign;
    res.zero_pad      = cur_flags.zero_pad;
    res.has_precision = prec_ok;
    res.long_mod      = cur_flags.long_mod;
    res.field_width   = cur_wacc;
    res.prec_value    = prec_ok ? cur_pacc : '0;
    res.prec_overflow = cur_povf;

    case (cur_phase)
      PH_FLAGS: begin
        if (ch == CH_HASH) begin
          flags_nxt.alt_form = 1'b1;
        end else if (ch == CH_MINUS) begin
          flags_nxt.left_align = 1'b1;
        end else if (ch == CH_PLUS) begin
          flags_nxt.force_sign = 1'b1;
        end else if (ch == CH_SPACE) begin
          flags_nxt.space_sign = 1'b1;
        end else if (ch == CH_ZERO) begin
          // single zero flag, then straight into the width digits
          flags_nxt.zero_pad = 1'b1;
          phase_nxt          = PH_WIDTH;
        end else if (is_digit) begin
          do_wdigit = 1'b1;
        end else begin
          do_after = 1'b1;
        end
      end
      PH_WIDTH: begin
        if (is_digit) begin
          do_wdigit = 1'b1;
        end else begin
          do_after = 1'b1;
        end
      end
      PH_PREC: begin
        if (is_digit) begin
          // once overflowed, further digits are swallowed
          if (!cur_povf) begin
            if (povf_step) begin
              povf_nxt = 1'b1;
              pacc_nxt = '0;
            end else begin
              pacc_nxt = psum;
            end
          end
        end else if (ch == CH_LONG) begin
          flags_nxt.long_mod = 1'b1;
          phase_nxt          = PH_LONG;
        end else begin
          do_finish = 1'b1;
        end
      end
      PH_LONG: begin
        do_finish = 1'b1;
      end
      default: begin
        // specifier finished: ignore bytes until the next start
      end
    endcase

    if (do_wdigit) begin
      if (wovf) begin
        // abort: report width so far, no conversion byte, no precision
        emit                = 1'b1;
        res.status          = ST_WIDTH_OVF;
        res.conv_char       = '0;
        res.has_precision   = 1'b0;
        res.prec_value      = '0;
        res.prec_overflow   = 1'b0;
        phase_nxt           = PH_DONE;
      end else begin
        wacc_nxt  = wsum;
        phase_nxt = PH_WIDTH;
      end
    end

    if (do_after) begin
      if (ch == CH_DOT) begin
        flags_nxt.dot = 1'b1;
        pacc_nxt      = '0;
        phase_nxt     = PH_PREC;
      end else if (ch == CH_LONG) begin
        flags_nxt.long_mod = 1'b1;
        phase_nxt          = PH_LONG;
      end else begin
        do_finish = 1'b1;
      end
    end

    if (do_finish) begin
      emit       = 1'b1;
      res.status = known_conv(ch) ? ST_OK : ST_BAD_CONV;
      phase_nxt  = PH_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FLAGS;
      flags_r <= '0;
      wacc_r  <= '0;
      pacc_r  <= '0;
      povf_r  <= 1'b0;
    end else if (in_xfer) begin
      phase_r <= phase_nxt;
      flags_r <= flags_nxt;
      wacc_r  <= wacc_nxt;
      pacc_r  <= pacc_nxt;
      povf_r  <= povf_nxt;
    end
  end

  // result register parts the two stream sides
  fsp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_xfer && emit),
    .load_data (res),
    .tready    (out_tready),
    .tvalid    (out_tvalid),
    .data      (out_res),
    .free      (out_free)
  );

  assign out_tdata = {out_res.prec_overflow, out_res.prec_value, out_res.field_width,
                      out_res.long_mod, out_res.has_precision, out_res.zero_pad,
                      out_res.space_sign, out_res.force_sign, out_res.left_align,
                      out_res.alt_form, out_res.conv_char, out_res.status};

  // a finished specifier stays finished until a start byte arrives
  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !start && phase_r == PH_DONE) |=> (phase_r == PH_DONE))
    else $error("parser left done phase without start");

  // every emitted result leaves the parser in the done phase
  a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && emit) |=> (phase_r == PH_DONE && out_tvalid))
    else $error("result emitted without closing the specifier");

  // precision reported present never coexists with precision overflow
  a_prec_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[15] && out_tdata[79]))
    else $error("precision both present and overflowed");

  // width abort carries no conversion byte and no precision
  a_wovf_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_res.status == ST_WIDTH_OVF) |->
      (out_res.conv_char == '0 && !out_res.has_precision && out_res.prec_value == '0))
    else $error("width overflow result carries conversion or precision");

endmodule
